FILE: sv/dfs_pkg.sv
// Package for the display fade sequencer.
// Holds phase and command types, result record and phase encoding.
// No dependencies.
package dfs_pkg;

    localparam int unsigned SHADE_W = 8;
    localparam int unsigned IMG_W   = 16;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned CMD_W   = 2;

    localparam logic [SHADE_W-1:0] FULL_SHADE = 8'd255;
    localparam logic [SHADE_W-1:0] RATE_RESET = 8'd8;

    // phase codes as seen on the result stream
    localparam logic [PHASE_W-1:0] PHC_DARKEN   = 2'd0;
    localparam logic [PHASE_W-1:0] PHC_DARK     = 2'd1;
    localparam logic [PHASE_W-1:0] PHC_BRIGHTEN = 2'd2;
    localparam logic [PHASE_W-1:0] PHC_BRIGHT   = 2'd3;

    typedef enum logic [3:0]
    {
        PH_DARKEN   = 4'b0001,
        PH_DARK     = 4'b0010,
        PH_BRIGHTEN = 4'b0100,
        PH_BRIGHT   = 4'b1000
    } phase_t;

    typedef enum logic [CMD_W-1:0]
    {
        CMD_TICK  = 2'd0,
        CMD_SHOW  = 2'd1,
        CMD_BLACK = 2'd2
    } cmd_t;

    typedef struct packed
    {
        logic [SHADE_W-1:0] shade_level;
        logic [IMG_W-1:0]   shown_image;
        logic               shows_image;
        logic [PHASE_W-1:0] phase;
    } result_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_DARKEN:   code = PHC_DARKEN;
            PH_DARK:     code = PHC_DARK;
            PH_BRIGHTEN: code = PHC_BRIGHTEN;
            PH_BRIGHT:   code = PHC_BRIGHT;
            default:     code = PHC_DARK;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/display_fade_sequencer.sv
// Display fade sequencer top level: request stream in, result stream out.
// Result valid in the cycle after the request is accepted. Throughput: one
// request per cycle unless m_tready stalls; the result register frees when taken.
// Reset: async active low; phase dark, shade 0, no image wanted, rate 8.
// Depends on dfs_pkg and dfs_core.
module display_fade_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] image_id
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] phase, [2] shows_image,
                                   // [18:3] shown_image, [26:19] shade_level
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata
);

    dfs_pkg::result_t result_next;
    dfs_pkg::result_t result_reg;
    logic             valid_reg, valid_next;
    logic             step;

    assign s_tready = !valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    dfs_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .cmd         (s_tuser),
        .img         (s_tdata),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .result_next (result_next)
    );

    assign valid_next = step || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, result_reg};

endmodule

FILE: sv/dfs_core.sv
// Fade state machine: phase, shade, image registers and fade rate.
// Computes the result for each accepted request from the updated state.
// Depends on dfs_pkg.
module dfs_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [dfs_pkg::CMD_W-1:0]     cmd,
    input  logic [dfs_pkg::IMG_W-1:0]     img,
    input  logic                          cfg_wen,
    input  logic [dfs_pkg::SHADE_W-1:0]   cfg_wdata,
    output dfs_pkg::result_t              result_next
);

    dfs_pkg::phase_t              phase_reg, phase_next;
    logic [dfs_pkg::SHADE_W-1:0]  shade_reg, shade_next;
    logic                         want_reg, want_next;
    logic [dfs_pkg::IMG_W-1:0]    current_reg, current_next;
    logic [dfs_pkg::IMG_W-1:0]    pending_reg, pending_next;
    logic [dfs_pkg::SHADE_W-1:0]  rate_reg;

    logic [dfs_pkg::SHADE_W:0]    up_sum;
    logic                         dark_end;
    logic                         bright_end;
    logic                         showing;

    assign up_sum     = {1'b0, shade_reg} + {1'b0, rate_reg};
    assign dark_end   = (shade_reg <= rate_reg);
    assign bright_end = (up_sum >= {1'b0, dfs_pkg::FULL_SHADE});

    always_comb
    begin
        phase_next   = phase_reg;
        shade_next   = shade_reg;
        want_next    = want_reg;
        current_next = current_reg;
        pending_next = pending_reg;
        case (dfs_pkg::cmd_t'(cmd))
            dfs_pkg::CMD_TICK:
            begin
                case (phase_reg)
                    dfs_pkg::PH_DARKEN:
                    begin
                        if (dark_end)
                        begin
                            if (want_reg)
                            begin
                                // reflect the overshoot into the new image
                                shade_next   = rate_reg - shade_reg;
                                current_next = pending_reg;
                                phase_next   = dfs_pkg::PH_BRIGHTEN;
                            end
                            else
                            begin
                                shade_next = '0;
                                phase_next = dfs_pkg::PH_DARK;
                            end
                        end
                        else
                        begin
                            shade_next = shade_reg - rate_reg;
                        end
                    end
                    dfs_pkg::PH_BRIGHTEN:
                    begin
                        if (bright_end)
                        begin
                            shade_next = dfs_pkg::FULL_SHADE;
                            phase_next = dfs_pkg::PH_BRIGHT;
                        end
                        else
                        begin
                            shade_next = up_sum[dfs_pkg::SHADE_W-1:0];
                        end
                    end
                    default:
                    begin
                        shade_next = shade_reg;
                    end
                endcase
            end
            dfs_pkg::CMD_SHOW:
            begin
                want_next    = 1'b1;
                pending_next = img;
                case (phase_reg)
                    dfs_pkg::PH_DARK:
                    begin
                        current_next = img;
                        phase_next   = dfs_pkg::PH_BRIGHTEN;
                    end
                    dfs_pkg::PH_BRIGHTEN, dfs_pkg::PH_BRIGHT:
                    begin
                        phase_next = dfs_pkg::PH_DARKEN;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            dfs_pkg::CMD_BLACK:
            begin
                want_next = 1'b0;
                if (phase_reg == dfs_pkg::PH_BRIGHTEN || phase_reg == dfs_pkg::PH_BRIGHT)
                begin
                    phase_next = dfs_pkg::PH_DARKEN;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign showing = (phase_next != dfs_pkg::PH_DARK);

    always_comb
    begin
        result_next.phase       = dfs_pkg::phase_code(phase_next);
        result_next.shows_image = showing;
        result_next.shown_image = showing ? current_next : '0;
        result_next.shade_level = shade_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dfs_pkg::PH_DARK;
            shade_reg <= '0;
            want_reg  <= 1'b0;
            rate_reg  <= dfs_pkg::RATE_RESET;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                shade_reg <= shade_next;
                want_reg  <= want_next;
            end
            if (cfg_wen)
            begin
                rate_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            current_reg <= current_next;
            pending_reg <= pending_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_bright_full: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dfs_pkg::PH_BRIGHT |-> shade_reg == dfs_pkg::FULL_SHADE)
        else $error("bright phase without full shade");

    a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dfs_pkg::PH_DARK |-> shade_reg == '0)
        else $error("dark phase with non-zero shade");

    a_show_wants: assert property (@(posedge clk) disable iff (!rst_n)
        step && cmd == dfs_pkg::CMD_SHOW |=> want_reg && phase_reg != dfs_pkg::PH_DARK)
        else $error("show request left no image wanted");
`endif

endmodule
